### hdl/ess_pkg.sv
// Package with shared constants, codes and types of the Euler state-space step unit.
`default_nettype none

package ess_pkg;

  // Model size and derived index widths.
  localparam int MAX_ORDER = 4;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int CNT_W     = $clog2(MAX_ORDER + 1);
  localparam int AIDX_W    = 2 * IDX_W;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_STEP   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Configuration register indexes and reset values.
  localparam int         ADDR_W      = 3;
  localparam logic       REG_DT      = 1'b0;
  localparam logic       REG_ORDER   = 1'b1;
  localparam logic [24:0] DT_RESET    = 25'd16777;
  localparam logic [2:0]  ORDER_RESET = 3'd1;

  // Shared multiplier operand and product widths.
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;

  // Configuration register contents.
  typedef struct packed {
    logic [24:0] dt_step;
    logic [2:0]  order;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/ess_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module ess_mul (
  input  wire                              clk,
  input  wire  signed [ess_pkg::OP_W-1:0]   op_a,
  input  wire  signed [ess_pkg::OP_W-1:0]   op_b,
  output logic signed [ess_pkg::PROD_W-1:0] prod
);
  import ess_pkg::*;

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

`default_nettype wire

### hdl/ess_apb.sv
// APB-style configuration registers for the period and the model order.
`default_nettype none

module ess_apb (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [ess_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ess_pkg::cfg_t              cfg
);
  import ess_pkg::*;

  logic wr_beat;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dt_step <= DT_RESET;
      cfg.order   <= ORDER_RESET;
    end else if (wr_beat) begin
      case (paddr[2])
        REG_DT:    cfg.dt_step <= pwdata[24:0];
        REG_ORDER: cfg.order   <= pwdata[2:0];
        default:   ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (paddr[2])
      REG_DT:    prdata = {7'd0, cfg.dt_step};
      REG_ORDER: prdata = {29'd0, cfg.order};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/euler_state_space_step_unit.sv
// Top level: forward Euler state-space stepper around one shared multiplier.
// A step with n active states (n = order clamped to 1..4) keeps busy high while
// each element takes n+1 multiply-accumulate terms through the shared multiplier
// (a multiply state, then an accumulate state per term), then two period products
// and an update. Element results leave one at a time, one strobe cycle each.
// Loads and clear complete at the accepting edge.
// Synchronous reset clears A, B, the state vector and the step counter.
`default_nettype none

module euler_state_space_step_unit (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire  [1:0]                 cmd,
  input  wire  [1:0]                 row,
  input  wire  [1:0]                 col,
  input  wire  signed [31:0]         value,
  output logic                       result_valid,
  output logic [1:0]                 index,
  output logic signed [31:0]         state_value,
  output logic [31:0]                step_index,
  output logic                       saturated,
  output logic                       last,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [ess_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ess_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_LO   = 3'd3;
  localparam logic [2:0] S_HI   = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  localparam int ACC_W  = 51;
  localparam int LO_W   = 51;
  localparam int FULL_W = 77;
  localparam int INC_W  = 53;
  localparam int NX_W   = 54;

  cfg_t                     cfg;
  logic [2:0]               state;
  logic signed [31:0]       a_coeffs     [MAX_ORDER*MAX_ORDER];
  logic signed [31:0]       b_coeffs     [MAX_ORDER];
  logic signed [31:0]       state_vector [MAX_ORDER];
  logic signed [31:0]       next_vec     [MAX_ORDER];
  logic [31:0]              step_counter;
  logic signed [31:0]       u_reg;
  logic [IDX_W-1:0]         elem;
  logic [CNT_W-1:0]         term;
  logic [CNT_W-1:0]         n_act;
  logic signed [ACC_W-1:0]  acc;
  logic [LO_W-1:0]          plo;

  logic [CNT_W-1:0]         term_m1;
  logic [IDX_W-1:0]         col_idx;
  logic [IDX_W-1:0]         x_addr;
  logic signed [31:0]       x_rd;
  logic signed [31:0]       a_rd;
  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  mac_term;
  logic [FULL_W-1:0]        full;
  logic signed [INC_W-1:0]  inc;
  logic signed [NX_W-1:0]   nx;
  logic signed [31:0]       nx_sat;
  logic                     nx_clip;

  // Configuration port.
  ess_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared multiplier.
  ess_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign busy = (state != S_IDLE);

  // Active order, clamped to the supported range.
  always_comb begin
    if (cfg.order == 3'd0) begin
      n_act = CNT_W'(1);
    end else if (int'(cfg.order) > MAX_ORDER) begin
      n_act = CNT_W'(MAX_ORDER);
    end else begin
      n_act = CNT_W'(cfg.order);
    end
  end

  // Term 0 is B times u; term t above zero is A[elem][t-1] times x[t-1].
  assign term_m1   = term - CNT_W'(1);
  assign col_idx   = term_m1[IDX_W-1:0];
  assign x_addr    = (state == S_UPD) ? elem : col_idx;
  assign x_rd      = state_vector[x_addr];
  assign a_rd      = a_coeffs[{elem, col_idx}];

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_LO: begin
        op_a = {7'd0, acc[25:0]};
        op_b = {8'd0, cfg.dt_step};
      end
      S_HI: begin
        op_a = {{8{acc[ACC_W-1]}}, acc[ACC_W-1:26]};
        op_b = {8'd0, cfg.dt_step};
      end
      default: begin
        if (term == CNT_W'(0)) begin
          op_a = {b_coeffs[elem][31], b_coeffs[elem]};
          op_b = {u_reg[31], u_reg};
        end else begin
          op_a = {a_rd[31], a_rd};
          op_b = {x_rd[31], x_rd};
        end
      end
    endcase
  end

  // Product floored to Q16.16 and widened for the accumulator.
  assign mac_term = {{3{prod[63]}}, prod[63:16]};

  // Increment: floor(d * dt / 2^24) from the high and low partial products.
  assign full = {prod[49], prod[49:0], 26'd0} + {26'd0, plo};
  assign inc  = full[FULL_W-1:24];
  assign nx   = {{(NX_W-32){x_rd[31]}}, x_rd} + {inc[INC_W-1], inc};

  // Saturation of the new state value to 32 bits.
  always_comb begin
    if (!nx[NX_W-1] && (nx[NX_W-2:31] != '0)) begin
      nx_sat  = 32'sh7FFF_FFFF;
      nx_clip = 1'b1;
    end else if (nx[NX_W-1] && (nx[NX_W-2:31] != '1)) begin
      nx_sat  = 32'sh8000_0000;
      nx_clip = 1'b1;
    end else begin
      nx_sat  = nx[31:0];
      nx_clip = 1'b0;
    end
  end

  // Sequencer, storage and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      step_counter <= 32'd0;
      for (int k = 0; k < MAX_ORDER * MAX_ORDER; k++) begin
        a_coeffs[k] <= 32'sd0;
      end
      for (int k = 0; k < MAX_ORDER; k++) begin
        b_coeffs[k]     <= 32'sd0;
        state_vector[k] <= 32'sd0;
      end
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd)
              CMD_LOAD_A: begin
                if (int'(row) < MAX_ORDER && int'(col) < MAX_ORDER) begin
                  a_coeffs[{row[IDX_W-1:0], col[IDX_W-1:0]}] <= value;
                end
              end
              CMD_LOAD_B: begin
                if (int'(row) < MAX_ORDER) begin
                  b_coeffs[row[IDX_W-1:0]] <= value;
                end
              end
              CMD_CLEAR: begin
                for (int k = 0; k < MAX_ORDER; k++) begin
                  state_vector[k] <= 32'sd0;
                end
              end
              default: begin
                u_reg <= value;
                elem  <= '0;
                term  <= '0;
                state <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= ((term == CNT_W'(0)) ? ACC_W'(0) : acc) + mac_term;
          if (term == n_act) begin
            state <= S_LO;
          end else begin
            term  <= term + CNT_W'(1);
            state <= S_MUL;
          end
        end
        S_LO: begin
          state <= S_HI;
        end
        S_HI: begin
          plo   <= prod[LO_W-1:0];
          state <= S_UPD;
        end
        S_UPD: begin
          result_valid   <= 1'b1;
          index          <= 2'(elem);
          state_value    <= x_rd;
          step_index     <= step_counter;
          saturated      <= nx_clip;
          last           <= (CNT_W'(elem) == n_act - CNT_W'(1));
          next_vec[elem] <= nx_sat;
          if (CNT_W'(elem) == n_act - CNT_W'(1)) begin
            // Commit the whole new vector after the last element.
            for (int k = 0; k < MAX_ORDER; k++) begin
              if (k < int'(n_act)) begin
                state_vector[k] <= (k == int'(elem)) ? nx_sat : next_vec[k];
              end
            end
            step_counter <= step_counter + 32'd1;
            state        <= S_IDLE;
          end else begin
            elem  <= elem + IDX_W'(1);
            term  <= '0;
            state <= S_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the forward Euler state-space step unit.
`timescale 1ns / 100ps

module tb;
  import ess_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 20;
  localparam logic [ADDR_W-1:0] DT_ADDR    = {REG_DT, 2'b00};
  localparam logic [ADDR_W-1:0] ORDER_ADDR = {REG_ORDER, 2'b00};
  localparam longint Q_MAX = (longint'(1) <<< 31) - 1;
  localparam longint Q_MIN = -(longint'(1) <<< 31);

  // One row of the directed table: a command, or a register write carried in v.
  typedef enum logic [1:0] {ROW_ITEM, ROW_DT, ROW_ORDER} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  cmd;
    logic [1:0]  r;
    logic [1:0]  c;
    logic [31:0] v;
    logic        typed;
    logic [31:0] e_val;
    logic [31:0] e_step;
    logic        e_sat;
  } dir_row_t;

  // One element result of a step.
  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] val;
    logic [31:0] step;
    logic        sat;
    logic        last;
  } elem_result_t;

  // Rows with a typed expectation run at order 1, so they give one beat each.
  dir_row_t dir_tab [0:32] = '{
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'd0, 1'b0},
    '{ROW_DT,    CMD_STEP,   2'd0, 2'd0, 32'h0100_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_LOAD_B, 2'd0, 2'd2, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 32'd1, 1'b1},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'd2, 1'b1},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h0000_0000, 1'b1, 32'h8000_0000, 32'd3, 1'b0},
    '{ROW_ITEM,  CMD_LOAD_A, 2'd0, 2'd0, 32'h8000_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h0000_0000, 1'b1, 32'h8000_0000, 32'd4, 1'b1},
    '{ROW_ITEM,  CMD_CLEAR,  2'd1, 2'd1, 32'h0000_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'd5, 1'b0},
    '{ROW_ITEM,  CMD_LOAD_A, 2'd3, 2'd3, 32'h0000_8000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_LOAD_A, 2'd1, 2'd2, 32'hFFFF_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_LOAD_A, 2'd2, 2'd1, 32'h0001_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_LOAD_B, 2'd3, 2'd3, 32'h0002_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_LOAD_B, 2'd1, 2'd0, 32'hFFFF_8000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_LOAD_A, 2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_DT,    CMD_STEP,   2'd0, 2'd0, 32'h0001_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ORDER, CMD_STEP,   2'd0, 2'd0, 32'h0000_0004, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h0003_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ORDER, CMD_STEP,   2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h0001_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ORDER, CMD_STEP,   2'd0, 2'd0, 32'h0000_0007, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_DT,    CMD_STEP,   2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h7FFF_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_DT,    CMD_STEP,   2'd0, 2'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h8000_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_DT,    CMD_STEP,   2'd0, 2'd0, 32'h0000_0001, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h1234_5678, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ORDER, CMD_STEP,   2'd0, 2'd0, 32'h0000_0003, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_CLEAR,  2'd2, 2'd3, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'd0, 1'b0},
    '{ROW_ITEM,  CMD_STEP,   2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'd0, 1'b0}
  };

  // Block ports, all driven to known values from time zero.
  logic                clk;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  logic [1:0]          cmd     = CMD_STEP;
  logic [1:0]          row     = 2'd0;
  logic [1:0]          col     = 2'd0;
  logic signed [31:0]  value   = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [31:0]         pwdata  = '0;
  wire                 busy;
  wire                 result_valid;
  wire  [1:0]          index;
  wire  signed [31:0]  state_value;
  wire  [31:0]         step_index;
  wire                 saturated;
  wire                 last;
  wire  [31:0]         prdata;
  wire                 pready;

  // Typed expectation that travels with the command it belongs to.
  logic                tag_typed = 1'b0;
  logic [31:0]         tag_val   = '0;
  logic [31:0]         tag_step  = '0;
  logic                tag_sat   = 1'b0;

  // Predictor state and configuration.
  int                  a_model [MAX_ORDER*MAX_ORDER];
  int                  b_model [MAX_ORDER];
  int                  x_model [MAX_ORDER];
  logic [31:0]         steps_taken;
  logic [24:0]         dt_model;
  logic [2:0]          order_model;
  elem_result_t        step_out [MAX_ORDER];
  elem_result_t        pending_q [$];

  // Run bookkeeping.
  int                  idle_pct     = 14;
  int                  idle_cycles  = 0;
  int                  fail_count   = 0;
  int                  cmds_taken   = 0;
  int                  steps_seen   = 0;
  int                  cfg_writes   = 0;
  int                  beats_seen   = 0;
  int                  clips_seen   = 0;

  euler_state_space_step_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .row          (row),
    .col          (col),
    .value        (value),
    .result_valid (result_valid),
    .index        (index),
    .state_value  (state_value),
    .step_index   (step_index),
    .saturated    (saturated),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one command to the model; for a step, fills step_out and returns its length.
  function automatic int euler_advance(logic [1:0] op, logic [1:0] r, logic [1:0] c,
                                       logic signed [31:0] v);
    int     n;
    longint acc;
    longint q;
    longint rem;
    longint inc;
    longint nx;
    int     next_x [MAX_ORDER];
    case (op)
      CMD_LOAD_A: begin
        a_model[r*MAX_ORDER + c] = v;
        return 0;
      end
      CMD_LOAD_B: begin
        b_model[r] = v;
        return 0;
      end
      CMD_CLEAR: begin
        foreach (x_model[k]) x_model[k] = 0;
        return 0;
      end
      default: ;
    endcase
    // Order 0 runs as 1; anything above the maximum runs at the maximum.
    n = (order_model == 3'd0) ? 1 :
        (order_model > MAX_ORDER) ? MAX_ORDER : int'(order_model);
    for (int i = 0; i < n; i++) begin
      acc = (longint'(b_model[i]) * longint'(v)) >>> 16;
      for (int j = 0; j < n; j++)
        acc += (longint'(a_model[i*MAX_ORDER + j]) * longint'(x_model[j])) >>> 16;
      // Split the derivative so the period product cannot overflow 64 bits.
      q   = acc >>> 24;
      rem = acc & longint'(24'hFF_FFFF);
      inc = q * longint'(dt_model) + ((rem * longint'(dt_model)) >>> 24);
      nx  = longint'(x_model[i]) + inc;
      step_out[i].sat = 1'b1;
      if (nx > Q_MAX) nx = Q_MAX;
      else if (nx < Q_MIN) nx = Q_MIN;
      else step_out[i].sat = 1'b0;
      next_x[i]        = int'(nx);
      step_out[i].idx  = 2'(i);
      step_out[i].val  = x_model[i];
      step_out[i].step = steps_taken;
      step_out[i].last = (i == n - 1);
    end
    for (int i = 0; i < n; i++) x_model[i] = next_x[i];
    steps_taken++;
    return n;
  endfunction

  function automatic void check_field(string what, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp, act);
      fail_count++;
    end
  endfunction

  // Observes every beat at the clock edge: results, register writes and commands.
  always @(posedge clk) begin
    int           n;
    logic         moved;
    elem_result_t want;
    if (rst) begin
      foreach (a_model[k]) a_model[k] = 0;
      foreach (b_model[k]) b_model[k] = 0;
      foreach (x_model[k]) x_model[k] = 0;
      steps_taken = '0;
      dt_model    = DT_RESET;
      order_model = ORDER_RESET;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      // Result beat against the oldest pending element.
      if (result_valid) begin
        moved = 1'b1;
        beats_seen++;
        if (saturated) clips_seen++;
        if (pending_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t ns: result beat with none pending, index %h value %h",
                     $time, index, state_value);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          check_field("index", want.idx, index);
          check_field("state_value", want.val, state_value);
          check_field("step_index", want.step, step_index);
          check_field("saturated", want.sat, saturated);
          check_field("last", want.last, last);
        end
      end
      // Register write.
      if (psel && penable && pwrite && pready) begin
        moved = 1'b1;
        cfg_writes++;
        if (paddr == DT_ADDR) dt_model = pwdata[24:0];
        else if (paddr == ORDER_ADDR) order_model = pwdata[2:0];
      end
      // Command beat.
      if (start && !busy) begin
        moved = 1'b1;
        cmds_taken++;
        if (cmd == CMD_STEP) steps_seen++;
        n = euler_advance(cmd, row, col, value);
        if (tag_typed)
          pending_q.push_back('{2'd0, tag_val, tag_step, tag_sat, 1'b1});
        else
          for (int k = 0; k < n; k++) pending_q.push_back(step_out[k]);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Watchdog: no beat for %0d cycles", IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Sends one command, with random idle cycles ahead of it, and waits for its beat.
  task automatic send_cmd(dir_row_t t);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    cmd       <= t.cmd;
    row       <= t.r;
    col       <= t.c;
    value     <= t.v;
    tag_typed <= t.typed;
    tag_val   <= t.e_val;
    tag_step  <= t.e_step;
    tag_sat   <= t.e_sat;
    do @(posedge clk); while (busy);
  endtask

  // Lets all pending results arrive, then covers the tail of the longest step.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes a register over APB and reads it back.
  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (addr == DT_ADDR) ? 32'(data[24:0]) : 32'(data[2:0]);
    check_field("register readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly modest Q16.16 values around zero, now and then any 32-bit pattern.
  function automatic logic [31:0] rand_q(int span_log2);
    int span;
    span = 1 << span_log2;
    if ($urandom_range(7) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Stimulus: directed table, then six random phases with fresh settings.
  initial begin
    dir_row_t t;
    int       pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      case (dir_tab[k].kind)
        ROW_DT: begin
          wait_drained();
          cfg_write(DT_ADDR, dir_tab[k].v);
        end
        ROW_ORDER: begin
          wait_drained();
          cfg_write(ORDER_ADDR, dir_tab[k].v);
        end
        default: send_cmd(dir_tab[k]);
      endcase
    end

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 14 : (ph < 4) ? 75 : 0;
      wait_drained();
      case ($urandom_range(5))
        0:       cfg_write(DT_ADDR, 32'h0000_0001);
        1:       cfg_write(DT_ADDR, 32'h0100_0000);
        default: cfg_write(DT_ADDR, $urandom_range(32'h0000_1000, 32'h0040_0000));
      endcase
      wait_drained();
      cfg_write(ORDER_ADDR, $urandom_range(7));
      // Program the whole model and start from rest.
      for (int k = 0; k < MAX_ORDER*MAX_ORDER + MAX_ORDER; k++) begin
        t = '0;
        if (k < MAX_ORDER*MAX_ORDER) begin
          t.cmd = CMD_LOAD_A;
          t.r   = 2'(k / MAX_ORDER);
          t.c   = 2'(k % MAX_ORDER);
        end else begin
          t.cmd = CMD_LOAD_B;
          t.r   = 2'(k - MAX_ORDER*MAX_ORDER);
          t.c   = 2'($urandom);
        end
        t.v = rand_q(16);
        send_cmd(t);
      end
      t     = '0;
      t.cmd = CMD_CLEAR;
      send_cmd(t);
      // Mostly steps, with coefficient changes and clears mixed in.
      for (int k = 0; k < 26; k++) begin
        t    = '0;
        t.r  = 2'($urandom);
        t.c  = 2'($urandom);
        pick = $urandom_range(99);
        if (pick < 10) begin
          t.cmd = CMD_LOAD_A;
          t.v   = rand_q(16);
        end else if (pick < 16) begin
          t.cmd = CMD_LOAD_B;
          t.v   = rand_q(16);
        end else if (pick < 22) begin
          t.cmd = CMD_CLEAR;
          t.v   = $urandom;
        end else begin
          t.cmd = CMD_STEP;
          t.v   = rand_q(20);
        end
        send_cmd(t);
      end
    end

    wait_drained();
    $display("Ran %0d commands (%0d steps) over %0d register writes.",
             cmds_taken, steps_seen, cfg_writes);
    $display("Compared %0d result beats, %0d of them flagged as clipped.",
             beats_seen, clips_seen);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
